// ===== hw/rtl/frag_pkg.sv =====
// ----------------------------------------------------------------------------
// frag_pkg
// Shared types and constants of the fragment reassembler.
// ----------------------------------------------------------------------------
package frag_pkg;
  localparam int unsigned HeaderBytes = 18;
  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [31:0] CrcInit = 32'hFFFFFFFF;
  localparam logic [7:0] Magic0 = 8'h53;
  localparam logic [7:0] Magic1 = 8'h41;
  localparam logic [7:0] Magic2 = 8'h52;
  localparam logic [7:0] Magic3 = 8'h31;

  typedef enum logic {
    OP_BYTE   = 1'b0,
    OP_VERIFY = 1'b1
  } op_t;

  typedef struct packed {
    logic        operation;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [7:0]  payload_length;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic        accepted;
    logic        transfer_active;
    logic        transfer_complete;
    logic        crc_matches;
    logic [63:0] missing_map;
    logic [15:0] current_transfer;
    logic [6:0]  received_total;
  } out_item_t;

  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : 32'd0);
    end
    return c;
  endfunction
endpackage

// ===== hw/rtl/frag_if.sv =====
// ----------------------------------------------------------------------------
// frag_in_if / frag_out_if
// Valid/ready channels of the fragment reassembler.
// ----------------------------------------------------------------------------
interface frag_in_if;
  logic               valid;
  logic               ready;
  frag_pkg::in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface frag_out_if;
  logic                valid;
  logic                ready;
  frag_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/frag_store.sv =====
// ----------------------------------------------------------------------------
// frag_store
// Byte store of the assembled transfer, one write and one registered read.
// ----------------------------------------------------------------------------
module frag_store #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned AW = 13
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== hw/rtl/fragment_reassembler.sv =====
// ----------------------------------------------------------------------------
// fragment_reassembler
// Header parser, fragment map and CRC-32 check over the assembled store.
// ----------------------------------------------------------------------------
// A payload byte's result, on the last byte, is held in the output register
// until taken. A verify walks the store one byte per cycle through its single
// read port, and no new item is taken until its result is loaded. The store
// has no reset; only bytes written by fragments are meaningful to a verify.
module fragment_reassembler #(
  parameter int unsigned CHUNK_BYTES   = 128,
  parameter int unsigned MAX_FRAGMENTS = 64,
  parameter int unsigned STORE_BYTES   = 8192
) (
  input logic clk,
  input logic rst_n,
  frag_in_if.sink    in_ch,
  frag_out_if.source out_ch
);
  import frag_pkg::*;

  localparam int unsigned AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int unsigned LW = $clog2(STORE_BYTES + 1);

  typedef enum logic [1:0] { S_RUN, S_WALK, S_LAST } st_t;
  st_t st_r;

  logic [7:0]  pos_r;
  logic        magic_r;
  logic [15:0] htid_r, hidx_r, hcnt_r;
  logic [31:0] hlen_r, hcrc_r;
  logic        fok_r, act_r;
  logic [15:0] aid_r;
  logic [6:0]  ecnt_r, rcnt_r;
  logic [LW-1:0] elen_r;
  logic [31:0] ecrc_r, crc_r;
  logic [63:0] map_r;
  logic [LW-1:0] wpos_r;
  logic        ov_r;
  out_item_t   od_r;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  frag_store #(.DEPTH(STORE_BYTES), .AW(AW)) u_store (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(in_ch.data.data_byte),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  assign in_ch.ready  = (st_r == S_RUN) && (!ov_r || out_ch.ready);
  assign out_ch.valid = ov_r;
  assign out_ch.data  = od_r;

  logic take;
  assign take = in_ch.valid && in_ch.ready;

  // load the output register
  logic ov_set;
  always_comb begin
    unique case (st_r)
      S_RUN:   ov_set = take && (in_ch.data.operation == OP_BYTE) && in_ch.data.last_byte;
      S_WALK:  ov_set = 1'b0;
      default: ov_set = !ov_r || out_ch.ready;
    endcase
  end

  // chunk write address
  logic [31:0] waddr32;
  assign waddr32 = hidx_r * CHUNK_BYTES + 32'(pos_r) - 32'(HeaderBytes);
  assign wr_en = take && (in_ch.data.operation == OP_BYTE) && fok_r &&
                 (pos_r >= 8'(HeaderBytes)) && (pos_r < in_ch.data.payload_length) &&
                 (waddr32 < STORE_BYTES);
  assign wr_addr = waddr32[AW-1:0];
  // hold the last byte on the read port while the result waits
  assign rd_addr = (st_r == S_LAST) ? wpos_r[AW-1:0] - AW'(1) : wpos_r[AW-1:0];

  function automatic logic [63:0] miss(logic a, logic [6:0] c, logic [63:0] m);
    logic [63:0] mask;
    mask = (c >= 7'd64) ? '1 : ((64'd1 << c) - 64'd1);
    return a ? (mask & ~m) : 64'd0;
  endfunction

  // header judgment on byte 17
  logic        hdr_pass;
  logic        newt;
  logic        bound_ok;
  logic [31:0] off_end;
  always_comb begin
    hdr_pass = (in_ch.data.payload_length >= 8'(HeaderBytes)) && magic_r &&
               (hcnt_r != 16'd0) && (hcnt_r <= MAX_FRAGMENTS) &&
               (hlen_r <= STORE_BYTES) && (hidx_r < hcnt_r);
    newt     = hdr_pass && (!act_r || htid_r != aid_r);
    off_end  = hidx_r * CHUNK_BYTES + 32'(in_ch.data.payload_length) - 32'(HeaderBytes);
    bound_ok = off_end <= STORE_BYTES;
  end

  logic [7:0] b;
  logic [31:0] hcrc_nxt;
  assign b = in_ch.data.data_byte;
  assign hcrc_nxt = {b, hcrc_r[31:8]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_RUN; pos_r <= '0; magic_r <= 1'b1;
      htid_r <= '0; hidx_r <= '0; hcnt_r <= '0; hlen_r <= '0; hcrc_r <= '0;
      fok_r <= 1'b0; act_r <= 1'b0; aid_r <= '0; ecnt_r <= '0; rcnt_r <= '0;
      elen_r <= '0; ecrc_r <= '0; map_r <= '0; ov_r <= 1'b0; wpos_r <= '0;
      crc_r <= CrcInit;
    end else begin
      ov_r <= ov_set || (ov_r && !out_ch.ready);
      unique case (st_r)
        S_RUN: begin
          if (take && in_ch.data.operation == OP_VERIFY) begin
            wpos_r <= '0;
            crc_r  <= CrcInit;
            st_r   <= (elen_r == '0) ? S_LAST : S_WALK;
          end else if (take) begin
            logic        f_ok;
            logic        a_n;
            logic [15:0] id_n;
            logic [6:0]  ec_n, rc_n;
            logic [63:0] mp_n;
            logic        acc;
            f_ok = fok_r; a_n = act_r; id_n = aid_r; ec_n = ecnt_r;
            rc_n = rcnt_r; mp_n = map_r;
            if (pos_r < 8'd4) begin
              logic m;
              unique case (pos_r[1:0])
                2'd0: m = (b == Magic0);
                2'd1: m = (b == Magic1);
                2'd2: m = (b == Magic2);
                default: m = (b == Magic3);
              endcase
              magic_r <= (pos_r == 8'd0) ? m : (magic_r && m);
            end else if (pos_r == 8'd4) htid_r[7:0] <= b;
            else if (pos_r == 8'd5) htid_r[15:8] <= b;
            else if (pos_r == 8'd6) hidx_r[7:0] <= b;
            else if (pos_r == 8'd7) hidx_r[15:8] <= b;
            else if (pos_r == 8'd8) hcnt_r[7:0] <= b;
            else if (pos_r == 8'd9) hcnt_r[15:8] <= b;
            else if (pos_r < 8'd14) hlen_r <= {b, hlen_r[31:8]};
            else if (pos_r < 8'd18) begin
              hcrc_r <= hcrc_nxt;
              if (pos_r == 8'd17) begin
                f_ok = hdr_pass && bound_ok;
                if (newt) begin
                  a_n = 1'b1; id_n = htid_r; ec_n = hcnt_r[6:0];
                  elen_r <= LW'(hlen_r); ecrc_r <= hcrc_nxt;
                  mp_n = '0; rc_n = '0;
                end
              end
            end
            acc = f_ok && (pos_r >= 8'd17);
            if (in_ch.data.last_byte) begin
              if (acc && hidx_r < 16'd64 && !mp_n[hidx_r[5:0]]) begin
                mp_n[hidx_r[5:0]] = 1'b1;
                rc_n = rc_n + 7'd1;
              end
              pos_r <= '0;
              fok_r <= 1'b0;
              od_r  <= '{kind: 1'b0, accepted: acc, transfer_active: a_n,
                        transfer_complete: a_n && (rc_n == ec_n), crc_matches: 1'b0,
                        missing_map: miss(a_n, ec_n, mp_n), current_transfer: id_n,
                        received_total: rc_n};
            end else begin
              pos_r <= (pos_r == 8'd255) ? pos_r : pos_r + 8'd1;
              fok_r <= f_ok;
            end
            act_r <= a_n; aid_r <= id_n; ecnt_r <= ec_n; rcnt_r <= rc_n; map_r <= mp_n;
          end
        end
        S_WALK: begin
          // read of byte wpos issued; consume previous read
          if (wpos_r != '0) crc_r <= crc_byte(crc_r, rd_data);
          wpos_r <= wpos_r + LW'(1);
          if (wpos_r + LW'(1) == elen_r) st_r <= S_LAST;
        end
        default: begin
          logic [31:0] c;
          logic        cpl;
          c = (elen_r == '0) ? crc_r : crc_byte(crc_r, rd_data);
          cpl = act_r && (rcnt_r == ecnt_r);
          if (!ov_r || out_ch.ready) begin
            od_r <= '{kind: 1'b1, accepted: 1'b0, transfer_active: act_r,
                      transfer_complete: cpl, crc_matches: cpl && ((~c) == ecrc_r),
                      missing_map: miss(act_r, ecnt_r, map_r), current_transfer: aid_r,
                      received_total: rcnt_r};
            st_r <= S_RUN;
          end
        end
      endcase
    end
  end
endmodule
